[src/psl_pkg.sv]
// Shared types, codes and helpers for the packet sequence loss monitor.
package psl_pkg;

	localparam int COUNT_WIDTH_DEF = 40;

	// Event kinds carried in the input sideband.
	localparam logic [1:0] MODE_PACKET   = 2'd0;
	localparam logic [1:0] MODE_FRAGMENT = 2'd1;
	localparam logic [1:0] MODE_CLEAR    = 2'd2;

	// Largest forward delta plus one; anything at or above is a reorder.
	localparam logic [31:0] FORWARD_LIMIT = 32'h7FFF_FFFF;

	localparam int IN_TDATA_W  = 96;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TUSER_W = 2;
	// Fixed-width part of a result: two gaps, delta and missing count.
	localparam int MEAS_W      = 191;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] seq_number;
		logic [63:0] arrival_time_us;
		logic        is_physical;
	} psl_item_t;

	typedef struct packed {
		logic [63:0] packet_gap_us;
		logic [63:0] wire_gap_us;
		logic [31:0] seq_delta;
		logic [30:0] missing_now;
		logic        is_reordered;
		logic        is_duplicate;
	} psl_meas_t;

	// Elapsed time from a stored stamp; zero when there is no stamp or time ran back.
	function automatic logic [63:0] gap_since(logic [63:0] prev, logic [63:0] now);
		if (prev != 64'd0 && now >= prev) begin
			return now - prev;
		end
		return 64'd0;
	endfunction

endpackage

[src/packet_sequence_loss_monitor.sv]
// Top level of the packet sequence loss monitor: stream ports, input register, assertions.
//
// Receive events arrive one per beat on the s_axis side: a packet (sequence number,
// microsecond stamp, physical-datagram flag), a fragment, which only moves the
// wire-arrival stamp, or a clear. Every event gives exactly one result beat on the
// m_axis side, in order. A packet result carries the gap since the previous packet
// stamp, the gap since the previous wire stamp, the modulo 2^32 delta to the newest
// sequence seen, the packets inferred lost just before it, duplicate and reorder
// flags, and the saturating loss, reorder and duplicate totals after the event. A gap
// reads zero when no earlier stamp exists or time went backwards. Fragment results
// carry only the wire gap; clear, unused-kind and disabled results are all zero.
// The block takes one beat per clock cycle sustained while m_axis_tready stays high; a
// result beat is offered once its input beat has passed the input register and then
// the result register. The rate is set by the loop that reads and rewrites the
// tracking state: the 64-bit stamp subtracts and compares, the 32-bit delta and a
// counter add.
// Write the enable register only while no beat is in flight.
module packet_sequence_loss_monitor
	import psl_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_wr_en,
	input  logic                    cfg_wr_data,   // enable
	// receive events
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [IN_TDATA_W-1:0]   s_axis_tdata,  // seq_number[31:0], arrival_time_us[95:32]
	input  logic [IN_TUSER_W-1:0]   s_axis_tuser,  // mode[1:0], is_physical[2]
	// results
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// packet_gap_us, wire_gap_us, seq_delta, missing_now, total_missing,
	// total_reordered, total_duplicates, then zero fill
	output logic [((MEAS_W + 3 * COUNT_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
	output logic [OUT_TUSER_W-1:0]  m_axis_tuser   // is_reordered[0], is_duplicate[1]
);

	localparam int OUT_BITS    = MEAS_W + 3 * COUNT_WIDTH;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int STAGE_W     = OUT_TDATA_W + OUT_TUSER_W;

	logic                   enable_q;
	logic                   valid_s1;
	psl_item_t              item_s1;
	logic                   fire;
	logic                   out_in_ready;
	psl_meas_t              meas;
	logic [COUNT_WIDTH-1:0] total_missing, total_reordered, total_duplicates;
	logic [OUT_TDATA_W-1:0] res_tdata;
	logic [STAGE_W-1:0]     stage_out;

	// Hold the enable bit; the user must write it only while the block is idle, which the block itself does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			enable_q <= cfg_wr_data;
		end
	end

	// Input register: take a beat when empty or when the held one advances.
	assign fire          = valid_s1 && out_in_ready;
	assign s_axis_tready = !valid_s1 || out_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.mode            <= s_axis_tuser[1:0];
			item_s1.is_physical     <= s_axis_tuser[2];
			item_s1.seq_number      <= s_axis_tdata[31:0];
			item_s1.arrival_time_us <= s_axis_tdata[95:32];
		end
	end

	// Classify the held event and advance the tracking state when it moves on.
	psl_track #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_track (
		.clk              (clk),
		.arst_n           (arst_n),
		.enable           (enable_q),
		.fire             (fire),
		.item             (item_s1),
		.meas             (meas),
		.total_missing    (total_missing),
		.total_reordered  (total_reordered),
		.total_duplicates (total_duplicates)
	);

	// Pack the result from the lowest bit up; zero fill to a whole byte.
	assign res_tdata = OUT_TDATA_W'({total_duplicates, total_reordered, total_missing,
		meas.missing_now, meas.seq_delta, meas.wire_gap_us, meas.packet_gap_us});

	psl_out_stage #(
		.DATA_W(STAGE_W)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (out_in_ready),
		.in_data   ({meas.is_duplicate, meas.is_reordered, res_tdata}),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (stage_out)
	);

	assign m_axis_tdata = stage_out[OUT_TDATA_W-1:0];
	assign m_axis_tuser = stage_out[STAGE_W-1:OUT_TDATA_W];

	// A packet is never both a duplicate and a reorder.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("duplicate and reorder flags both set");

	// Inferred loss only comes with forward progress, never with a flag.
	a_missing_no_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[190:160] != 31'd0) |-> (m_axis_tuser == 2'b00))
		else $error("missing count reported on a flagged packet");

	// A disabled event yields an all-zero result.
	a_disabled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !enable_q) |=> (m_axis_tdata == '0 && m_axis_tuser == '0))
		else $error("disabled event gave a nonzero result");

	// A held event stays until it moves into the result register.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire) |=> valid_s1)
		else $error("input register dropped an event");

endmodule

[src/psl_track.sv]
// Tracking state and per-event classification of the loss monitor.
module psl_track
	import psl_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   enable,
	input  logic                   fire,
	input  psl_item_t              item,
	output psl_meas_t              meas,
	output logic [COUNT_WIDTH-1:0] total_missing,
	output logic [COUNT_WIDTH-1:0] total_reordered,
	output logic [COUNT_WIDTH-1:0] total_duplicates
);

	localparam int SUM_W = ((COUNT_WIDTH > 31) ? COUNT_WIDTH : 31) + 1;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic                   seen_first_q, seen_first_d;
	logic [31:0]            newest_seq_q, newest_seq_d;
	logic [63:0]            arrival_stamp_q, arrival_stamp_d;
	logic [63:0]            wire_stamp_q, wire_stamp_d;
	logic [COUNT_WIDTH-1:0] missing_cnt_q, missing_cnt_d;
	logic [COUNT_WIDTH-1:0] reorder_cnt_q, reorder_cnt_d;
	logic [COUNT_WIDTH-1:0] dup_cnt_q, dup_cnt_d;

	logic [31:0]            delta;
	logic [30:0]            missing;
	logic [COUNT_WIDTH-1:0] missing_sat, reorder_sat, dup_sat;

	function automatic logic [COUNT_WIDTH-1:0] sat_add(logic [COUNT_WIDTH-1:0] cnt,
			logic [30:0] add);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(cnt) + SUM_W'(add);
		if (sum > SUM_W'(CNT_MAX)) begin
			return CNT_MAX;
		end
		return sum[COUNT_WIDTH-1:0];
	endfunction

	assign delta       = item.seq_number - newest_seq_q;
	assign missing     = 31'(delta - 32'd1);
	assign missing_sat = sat_add(missing_cnt_q, missing);
	assign reorder_sat = sat_add(reorder_cnt_q, 31'd1);
	assign dup_sat     = sat_add(dup_cnt_q, 31'd1);

	always_comb begin
		meas             = '0;
		total_missing    = '0;
		total_reordered  = '0;
		total_duplicates = '0;
		seen_first_d     = seen_first_q;
		newest_seq_d     = newest_seq_q;
		arrival_stamp_d  = arrival_stamp_q;
		wire_stamp_d     = wire_stamp_q;
		missing_cnt_d    = missing_cnt_q;
		reorder_cnt_d    = reorder_cnt_q;
		dup_cnt_d        = dup_cnt_q;
		if (enable) begin
			unique case (item.mode)
				MODE_FRAGMENT: begin
					meas.wire_gap_us = gap_since(wire_stamp_q, item.arrival_time_us);
					wire_stamp_d     = item.arrival_time_us;
				end
				MODE_CLEAR: begin
					seen_first_d    = 1'b0;
					newest_seq_d    = '0;
					arrival_stamp_d = '0;
					wire_stamp_d    = '0;
					missing_cnt_d   = '0;
					reorder_cnt_d   = '0;
					dup_cnt_d       = '0;
				end
				MODE_PACKET: begin
					if (item.is_physical) begin
						meas.wire_gap_us = gap_since(wire_stamp_q, item.arrival_time_us);
						wire_stamp_d     = item.arrival_time_us;
					end
					meas.packet_gap_us = gap_since(arrival_stamp_q, item.arrival_time_us);
					arrival_stamp_d    = item.arrival_time_us;
					if (!seen_first_q) begin
						seen_first_d = 1'b1;
						newest_seq_d = item.seq_number;
					end else begin
						meas.seq_delta = delta;
						if (delta == 32'd0) begin
							meas.is_duplicate = 1'b1;
							dup_cnt_d         = dup_sat;
						end else if (delta < FORWARD_LIMIT) begin
							meas.missing_now = missing;
							missing_cnt_d    = missing_sat;
							newest_seq_d     = item.seq_number;
						end else begin
							meas.is_reordered = 1'b1;
							reorder_cnt_d     = reorder_sat;
						end
					end
					total_missing    = missing_cnt_d;
					total_reordered  = reorder_cnt_d;
					total_duplicates = dup_cnt_d;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_first_q    <= 1'b0;
			newest_seq_q    <= '0;
			arrival_stamp_q <= '0;
			wire_stamp_q    <= '0;
			missing_cnt_q   <= '0;
			reorder_cnt_q   <= '0;
			dup_cnt_q       <= '0;
		end else if (fire) begin
			seen_first_q    <= seen_first_d;
			newest_seq_q    <= newest_seq_d;
			arrival_stamp_q <= arrival_stamp_d;
			wire_stamp_q    <= wire_stamp_d;
			missing_cnt_q   <= missing_cnt_d;
			reorder_cnt_q   <= reorder_cnt_d;
			dup_cnt_q       <= dup_cnt_d;
		end
	end

endmodule

[src/psl_out_stage.sv]
// Result register with handshake toward the output stream.
module psl_out_stage #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] out_data
);

	logic              valid_s2;
	logic [DATA_W-1:0] data_s2;

	// Load a new result whenever the held one is gone or leaves this cycle.
	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= in_data;
		end
	end

endmodule
